### rtl/rolling_word_checksum_macros.svh
// Assertion macros used by the checksum input stage
`ifndef ROLLING_WORD_CHECKSUM_MACROS_SVH
`define ROLLING_WORD_CHECKSUM_MACROS_SVH

// same-cycle implication
`define RWC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rolling word checksum: same-cycle check failed");

// next-cycle implication
`define RWC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rolling word checksum: next-cycle check failed");

`endif

### rtl/rwc_pkg.sv
// Types, constants and helper functions for the rolling word checksum
package rwc_pkg;

   localparam int MaxWindowWords = 2048;
   localparam int PtrWidth       = $clog2(MaxWindowWords);
   localparam int WinWidth       = 12;
   localparam int SumWidth       = 16;
   localparam int StartWidth     = 30;
   localparam int WordWidth      = 32;
   localparam int ProdWidth      = WinWidth + SumWidth;

   localparam logic [WinWidth-1:0] ResetWindow = WinWidth'(256);
   localparam logic [WinWidth-1:0] MaxWindow   = WinWidth'(MaxWindowWords);

   typedef struct packed {
      logic [SumWidth-1:0]   entering;
      logic                  use_leaving;
      logic                  emit;
      logic [StartWidth-1:0] window_start;
   } stage_type;

   function automatic logic [SumWidth-1:0] word_value(input logic [WordWidth-1:0] w);
      logic [SumWidth-1:0] hi;
      logic [SumWidth-1:0] lo;
      hi = {w[15:8], 8'h00};
      lo = {{8{w[7]}}, w[7:0]};
      return hi + lo;
   endfunction

   function automatic logic [WinWidth-1:0] effective_window(input logic [WinWidth-1:0] w);
      logic [WinWidth-1:0] n;
      if (w == '0) begin
         n = WinWidth'(1);
      end else if (w > MaxWindow) begin
         n = MaxWindow;
      end else begin
         n = w;
      end
      return n;
   endfunction

endpackage

### rtl/rwc_front.sv
// Input stage: ring pointer, word counter, window memory and input register
module rwc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [rwc_pkg::WinWidth-1:0]  win_n,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rwc_pkg::WordWidth-1:0] req_tdata,   // [31:0] data_word
   output logic                          stg_valid,
   input  logic                          stg_ready,
   output rwc_pkg::stage_type            stg,
   output logic [rwc_pkg::SumWidth-1:0]  leaving_raw
);
   import rwc_pkg::*;
   `include "rolling_word_checksum_macros.svh"

   logic [SumWidth-1:0]   mem_store [MaxWindowWords];
   logic [SumWidth-1:0]   rdata_ff;
   logic [PtrWidth-1:0]   ptr_ff, ptr_in;
   logic [PtrWidth-1:0]   ptr_use;
   logic [WinWidth-1:0]   ptr_inc;
   logic [StartWidth-1:0] count_ff, count_in;
   logic                  full_ff, full_in;
   logic                  valid_ff;
   stage_type             stg_ff, stg_in;
   logic                  accept;

   assign req_tready = !valid_ff || stg_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      ptr_use  = (WinWidth'(ptr_ff) >= win_n) ? '0 : ptr_ff;
      ptr_inc  = WinWidth'(ptr_use) + WinWidth'(1);
      ptr_in   = (ptr_inc >= win_n) ? '0 : ptr_inc[PtrWidth-1:0];
      count_in = count_ff + StartWidth'(1);
      full_in  = full_ff || (count_in >= StartWidth'(win_n));
      stg_in.entering     = word_value(req_tdata);
      stg_in.use_leaving  = full_ff;
      stg_in.emit         = full_in;
      stg_in.window_start = count_in - StartWidth'(win_n);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ptr_ff   <= '0;
         count_ff <= '0;
         full_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         ptr_ff   <= '0;
         count_ff <= '0;
         full_ff  <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
         ptr_ff   <= ptr_in;
         count_ff <= count_in;
         full_ff  <= full_in;
      end else if (stg_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_ff              <= stg_in;
         rdata_ff            <= mem_store[ptr_use];
         mem_store[ptr_use]  <= stg_in.entering;
      end
   end

   assign stg_valid   = valid_ff;
   assign stg         = stg_ff;
   assign leaving_raw = rdata_ff;

   `RWC_ASSERT_NOW(a_ptr_in_window, clock, reset, 1'b1, WinWidth'(ptr_ff) < win_n)
   `RWC_ASSERT_NOW(a_fill_count, clock, reset, !full_ff, count_ff < StartWidth'(win_n))
   `RWC_ASSERT_NEXT(a_full_sticks, clock, reset, full_ff && !csr_wr_en, full_ff)
endmodule

### rtl/rwc_sum.sv
// Sum stage: rolling sums update and result register
module rwc_sum (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [rwc_pkg::WinWidth-1:0]  win_n,
   input  logic                          stg_valid,
   output logic                          stg_ready,
   input  rwc_pkg::stage_type            stg,
   input  logic [rwc_pkg::SumWidth-1:0]  leaving_raw,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [63:0]                   rsp_tdata    // [31:0] checksum, [61:32] window_start
);
   import rwc_pkg::*;

   logic [SumWidth-1:0]   plain_ff, plain_in;
   logic [SumWidth-1:0]   weighted_ff, weighted_in;
   logic [SumWidth-1:0]   leaving;
   logic [ProdWidth-1:0]  prod;
   logic                  out_valid_ff;
   logic [SumWidth-1:0]   out_plain_ff;
   logic [SumWidth-1:0]   out_weighted_ff;
   logic [StartWidth-1:0] out_start_ff;
   logic                  advance;

   assign stg_ready = !out_valid_ff || rsp_tready;
   assign advance   = stg_valid && stg_ready;

   always_comb begin
      leaving     = stg.use_leaving ? leaving_raw : '0;
      prod        = ProdWidth'(win_n) * ProdWidth'(leaving);
      plain_in    = plain_ff - leaving + stg.entering;
      weighted_in = weighted_ff - prod[SumWidth-1:0] + plain_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plain_ff     <= '0;
         weighted_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else if (csr_wr_en) begin
         plain_ff    <= '0;
         weighted_ff <= '0;
      end else if (advance) begin
         plain_ff     <= plain_in;
         weighted_ff  <= weighted_in;
         out_valid_ff <= stg.emit;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_plain_ff    <= plain_in;
         out_weighted_ff <= weighted_in;
         out_start_ff    <= stg.window_start;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_start_ff, out_weighted_ff, out_plain_ff};
endmodule

### rtl/rolling_word_checksum.sv
// Rolling word checksum: top level with window size register
//
// Takes one 32-bit word per cycle unless the output stalls, and returns the
// 32-bit rolling checksum of the last N words with the index of the window's
// first word. Each word passes through two register stages: the input stage
// reads and writes the window memory at the ring pointer, the sum stage
// updates both sums with one 12 x 16 multiply. The input register holds each
// word until the sum stage loads the result register from it. Throughput is
// one word per cycle unless the output stalls, set by the single memory port
// used once per word. A write to csr_wr_data restarts the stream; the first
// N-1 words after it only fill the window and give no result.
module rolling_word_checksum (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data,  // [11:0] window_words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] data_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata     // [31:0] checksum, [61:32] window_start
);
   import rwc_pkg::*;

   logic [WinWidth-1:0] window_ff;
   logic [WinWidth-1:0] win_n;
   logic                stg_valid;
   logic                stg_ready;
   stage_type           stg;
   logic [SumWidth-1:0] leaving_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= ResetWindow;
      end else if (csr_wr_en) begin
         window_ff <= csr_wr_data;
      end
   end

   assign win_n = effective_window(window_ff);

   rwc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .win_n       (win_n),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .stg_valid   (stg_valid),
      .stg_ready   (stg_ready),
      .stg         (stg),
      .leaving_raw (leaving_raw)
   );

   rwc_sum u_sum (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .win_n       (win_n),
      .stg_valid   (stg_valid),
      .stg_ready   (stg_ready),
      .stg         (stg),
      .leaving_raw (leaving_raw),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );
endmodule

### tb/sv/rolling_word_checksum_tb.sv
// Self-checking testbench for the rolling word checksum block
`timescale 1ns / 100ps

module rolling_word_checksum_tb;
   import rwc_pkg::*;

   typedef struct {
      logic [WordWidth-1:0]  checksum;
      logic [StartWidth-1:0] window_start;
   } sum_rec_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [WinWidth-1:0]   csr_wr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [WordWidth-1:0]  req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [63:0]           rsp_tdata;

   logic [SumWidth-1:0]   word_ring [MaxWindowWords];
   logic [WinWidth-1:0]   span_reg;
   logic [SumWidth-1:0]   plain_acc;
   logic [SumWidth-1:0]   weighted_acc;
   logic [31:0]           stream_count;
   int unsigned           ring_slot;
   bit                    span_full;

   sum_rec_type           pending_sums[$];
   int                    mismatch_count = 0;
   int                    sink_hold = 0;
   bit                    source_calm = 1'b0;
   bit                    sink_calm = 1'b0;

   rolling_word_checksum dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int draw_wait(input bit calm);
      if (calm || $urandom_range(0, 2) == 0) begin
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   function automatic int unsigned span_words();
      if (span_reg == '0) begin
         return 1;
      end else if (span_reg > MaxWindowWords) begin
         return MaxWindowWords;
      end
      return span_reg;
   endfunction

   function automatic void restart_sums();
      plain_acc    = '0;
      weighted_acc = '0;
      stream_count = '0;
      ring_slot    = 0;
      span_full    = 1'b0;
   endfunction

   function automatic void roll_word(input logic [WordWidth-1:0] w);
      int unsigned         n;
      logic [SumWidth-1:0] entering;
      logic [SumWidth-1:0] leaving;
      logic [31:0]         scaled;
      sum_rec_type         rec;
      n = span_words();
      // signed low byte: subtract 256 when its sign bit is set
      entering = w[15:0] - (w[7] ? 16'h0100 : 16'h0000);
      if (ring_slot >= n) begin
         ring_slot = 0;
      end
      leaving = span_full ? word_ring[ring_slot] : '0;
      word_ring[ring_slot] = entering;
      scaled       = n * leaving;
      plain_acc    = plain_acc - leaving + entering;
      weighted_acc = weighted_acc - scaled[SumWidth-1:0] + plain_acc;
      ring_slot    = (ring_slot + 1 >= n) ? 0 : ring_slot + 1;
      stream_count = stream_count + 1;
      if (!span_full && stream_count >= n) begin
         span_full = 1'b1;
      end
      if (span_full) begin
         rec.checksum     = {weighted_acc, plain_acc};
         rec.window_start = StartWidth'(stream_count - n);
         pending_sums.push_back(rec);
      end
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   task automatic check_result(input logic [63:0] beat);
      sum_rec_type want;
      if (pending_sums.size() == 0) begin
         report("unexpected transaction", beat, '0);
         return;
      end
      want = pending_sums.pop_front();
      if (beat[31:0] !== want.checksum) begin
         report("checksum", beat[31:0], want.checksum);
      end
      if (beat[61:32] !== want.window_start) begin
         report("window_start", beat[61:32], want.window_start);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sink_hold = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result(rsp_tdata);
            sink_hold = draw_wait(sink_calm);
         end
         if (sink_hold > 0) begin
            rsp_tready <= 1'b0;
            sink_hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_word(input logic [WordWidth-1:0] w);
      int gap;
      gap = draw_wait(source_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      roll_word(w);
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) begin
         send_word($urandom);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_sums.size() != 0) @(posedge clock);
   endtask

   // let words still in the pipeline that give no result pass through
   task automatic settle();
      wait_drained();
      repeat (6) @(posedge clock);
   endtask

   task automatic write_window(input logic [WinWidth-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      span_reg = value;
      restart_sums();
   endtask

   task automatic test_reset_window();
      send_random(span_words() + 12);
   endtask

   task automatic test_single_word_window();
      logic [WordWidth-1:0] corner [16] = '{
         32'h0000_0000, 32'hffff_ffff, 32'h0000_0080, 32'h0000_007f,
         32'h0000_00ff, 32'h0000_ff00, 32'h0000_8000, 32'h0000_7f80,
         32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678, 32'h0000_01ff,
         32'h0000_fe01, 32'ha5a5_a5a5, 32'h5a5a_5a5a, 32'h0000_8080};
      write_window(WinWidth'(1));
      foreach (corner[i]) begin
         send_word(corner[i]);
      end
      write_window('0);
      send_word(32'hffff_ff80);
      send_word(32'h0000_0001);
      send_word(32'h0000_7fff);
      send_word(32'hffff_0000);
   endtask

   task automatic test_restart_mid_fill();
      write_window(WinWidth'(6));
      send_random(3);
      write_window(WinWidth'(6));
      send_random(10);
      write_window(WinWidth'(9));
      send_random(12);
   endtask

   task automatic test_pause_until_drained();
      write_window(WinWidth'(5));
      send_random(20);
      wait_drained();
      send_random(20);
      wait_drained();
      send_random(8);
   endtask

   task automatic test_random_windows();
      int total;
      int n;
      int count;
      total = 0;
      while (total < 220) begin
         case ($urandom_range(0, 9))
            0:       n = $urandom_range(0, 2);
            1, 2:    n = $urandom_range(13, 64);
            default: n = $urandom_range(1, 12);
         endcase
         source_calm = ($urandom_range(0, 3) == 0);
         sink_calm   = ($urandom_range(0, 3) == 0);
         write_window(WinWidth'(n));
         if ($urandom_range(0, 4) == 0) begin
            count = $urandom_range(1, n + 1);
         end else begin
            count = n + $urandom_range(5, 40);
         end
         for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 59) == 0) begin
               wait_drained();
            end
            send_word($urandom);
         end
         total += count;
      end
      source_calm = 1'b0;
      sink_calm   = 1'b0;
   endtask

   task automatic test_largest_windows();
      write_window(WinWidth'(MaxWindowWords));
      send_random(24);
      write_window('1);
      send_random(16);
      write_window(WinWidth'(3));
      send_random(10);
   endtask

   initial begin
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      rsp_tready  <= 1'b0;
      span_reg = ResetWindow;
      restart_sums();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_window();
      test_single_word_window();
      test_restart_mid_fill();
      test_pause_until_drained();
      test_random_windows();
      test_largest_windows();

      settle();
      if (mismatch_count == 0) begin
         $display("rolling_word_checksum regression: pass");
      end else begin
         $display("rolling_word_checksum regression: fail");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("rolling_word_checksum regression: fail");
      $finish;
   end

endmodule
